/* sv/integer_to_text_formatter_macros.svh */
// Assertion macros shared by the checker
`ifndef INTEGER_TO_TEXT_FORMATTER_MACROS_SVH
`define INTEGER_TO_TEXT_FORMATTER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ITF_CHK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define ITF_CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/itf_pkg.sv */
package itf_pkg;

  // Stream payload widths
  localparam int IN_BITS  = 168;
  localparam int OUT_BITS = 72;
  localparam int TEXT_BITS = 64;
  localparam int COUNT_BITS = 4;

  // Flag bit positions in format_flags
  localparam int FLG_ZERO   = 0;
  localparam int FLG_LEFT   = 1;
  localparam int FLG_PLUS   = 2;
  localparam int FLG_SPACE  = 3;
  localparam int FLG_HASH   = 4;
  localparam int FLG_PREC   = 5;
  localparam int FLG_GROUP  = 6;
  localparam int FLG_SIGNED = 7;

  // Radix codes (log2 of radix; zero selects decimal)
  localparam logic [2:0] RADIX_DEC = 3'd0;
  localparam logic [2:0] RADIX_BIN = 3'd1;
  localparam logic [2:0] RADIX_B4  = 3'd2;
  localparam logic [2:0] RADIX_OCT = 3'd3;
  localparam logic [2:0] RADIX_HEX = 3'd4;

  // ASCII characters
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LX    = 8'h78;

  // Classified number handed from front to back
  typedef struct packed {
    logic       neg;
    logic [2:0] radix;
    logic       zero_pad;
    logic       left;
    logic       plus;
    logic       space;
    logic       hash;
    logic       prec_on;
    logic       group;
    logic       upper;
    logic       mag_zero;
    logic [7:0] prec;
    logic [7:0] width;
  } itf_desc_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DABBLE, S_GEN, S_LAYOUT, S_LEAD, S_SIGN, S_PFX, S_MID,
    S_ZERO, S_DRD, S_DPUT, S_TRAIL, S_FINAL
  } itf_state_t;

  // Digit value to ASCII
  function automatic logic [7:0] itf_digit_char(input logic [3:0] d, input logic up);
    if (d < 4'd10) begin
      return CH_ZERO + {4'd0, d};
    end else begin
      return (up ? CH_UA : CH_LA) + {4'd0, d} - 8'd10;
    end
  endfunction

endpackage

/* sv/itf_front.sv */
module itf_front import itf_pkg::*; #(
  parameter int VALUE_BITS  = 128,
  parameter int FIELD_LIMIT = 255
) (
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_BITS-1:0]    s_tdata,
  input  logic                  full,
  output logic                  push,
  output logic [VALUE_BITS-1:0] mag,
  output itf_desc_t             desc
);

  localparam int SB_W = $clog2(VALUE_BITS);
  localparam logic [7:0] FL8 = (FIELD_LIMIT > 255) ? 8'd255 : 8'(FIELD_LIMIT);

  logic [127:0]            raw;
  logic [VALUE_BITS-1:0]   v_in, v, smask, lmask, negv;
  logic [SB_W-1:0]         sb;
  logic [6:0]              sign_bit;
  logic [2:0]              radix_in;
  logic [7:0]              prec_in, width_in, flags;
  logic                    sgn;
  logic                    neg;

  assign s_tready = !full;
  assign push     = s_tvalid && !full;

  assign raw      = s_tdata[127:0];
  assign sign_bit = s_tdata[134:128];
  assign radix_in = s_tdata[137:135];
  assign prec_in  = s_tdata[145:138];
  assign width_in = s_tdata[153:146];
  assign flags    = s_tdata[161:154];
  assign sgn      = flags[FLG_SIGNED];

  // Mask at the sign bit and fold to magnitude
  always_comb begin
    v_in  = raw[VALUE_BITS-1:0];
    sb    = (sign_bit >= 7'(VALUE_BITS-1)) ? SB_W'(VALUE_BITS-1) : sign_bit[SB_W-1:0];
    smask = VALUE_BITS'(1) << sb;
    lmask = VALUE_BITS'(smask << 1) - VALUE_BITS'(1);
    v     = v_in & lmask;
    negv  = (~v + VALUE_BITS'(1)) & lmask;
    mag   = v;
    neg   = 1'b0;
    if (sgn) begin
      if (v == smask) begin
        neg = 1'b1;
      end else if ((v & smask) != '0) begin
        mag = negv & ~smask;
        neg = 1'b1;
      end else begin
        mag = v & ~smask;
      end
    end
  end

  // Flag cleanup and radix decode
  always_comb begin
    unique case (radix_in) inside
      RADIX_BIN, RADIX_B4, RADIX_OCT, RADIX_HEX: desc.radix = radix_in;
      default: desc.radix = RADIX_DEC;
    endcase
    desc.neg      = neg;
    desc.mag_zero = (mag == '0);
    desc.zero_pad = flags[FLG_ZERO] && !(flags[FLG_PREC] || flags[FLG_LEFT]);
    desc.left     = flags[FLG_LEFT];
    desc.plus     = flags[FLG_PLUS] && sgn;
    desc.space    = flags[FLG_SPACE] && sgn;
    desc.hash     = flags[FLG_HASH] && !(desc.mag_zero && desc.radix != RADIX_OCT);
    desc.prec_on  = flags[FLG_PREC];
    desc.group    = flags[FLG_GROUP];
    desc.upper    = s_tdata[162];
    desc.prec     = (prec_in > FL8) ? FL8 : prec_in;
    desc.width    = (width_in > FL8) ? FL8 : width_in;
  end

endmodule

/* sv/itf_queue.sv */
module itf_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  logic [W-1:0] entries [2];
  logic         wr_ptr, rd_ptr;
  logic [1:0]   count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign rdata = entries[rd_ptr];

  // Two-entry queue between front and back
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= wdata;
  end

endmodule

/* sv/itf_back.sv */
module itf_back import itf_pkg::*; #(
  parameter int VALUE_BITS         = 128,
  parameter int DIGIT_BUFFER_DEPTH = 144,
  parameter int FIELD_LIMIT        = 255,
  parameter int CHARS_PER_RESULT   = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_empty,
  input  logic [VALUE_BITS-1:0] q_mag,
  input  itf_desc_t             q_desc,
  output logic                  q_pop,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_BITS-1:0]   m_tdata,
  output logic                  m_tlast
);

  localparam int NEED      = VALUE_BITS + VALUE_BITS / 3 + 2;
  localparam int DIG_DEPTH = (DIGIT_BUFFER_DEPTH > NEED) ? DIGIT_BUFFER_DEPTH : NEED;
  localparam int DA_W      = $clog2(DIG_DEPTH);
  localparam int DL_W      = $clog2(DIG_DEPTH + 1);
  localparam int NDEC      = (VALUE_BITS * 31) / 100 + 2;
  localparam int BCD_W     = NDEC * 4;
  localparam int BC_W      = $clog2(VALUE_BITS);
  localparam int LW        = $clog2(FIELD_LIMIT + DIG_DEPTH + 8) + 1;
  localparam int CK_W      = CHARS_PER_RESULT * 8;
  localparam logic [COUNT_BITS-1:0] CPR_C = COUNT_BITS'(CHARS_PER_RESULT);

  itf_state_t state, state_next;
  itf_desc_t  d;

  logic [VALUE_BITS-1:0] val, val_sh;
  logic [BCD_W-1:0]      bcd, bcd_adj, bcd_sh;
  logic [BC_W-1:0]       bitcnt;
  logic [DL_W-1:0]       dlen, act;
  logic [1:0]            gcnt;
  logic [7:0]            mem [DIG_DEPTH];
  logic [7:0]            mem_q;
  logic [LW-1:0]         lead, zeros, trail;
  logic                  has_sign, has_mid;
  logic [7:0]            sign_ch, mid_ch;
  logic [CK_W-1:0]       chunk, out_chunk;
  logic [COUNT_BITS-1:0] cnt, out_cnt;

  // Digit generation signals
  logic [3:0] gen_d, kmask;
  logic       rest_zero, comma_now;
  logic [7:0] gen_ch;

  // Layout signals
  logic [LW-1:0] a0, p, w, len1, z1, len2, z2, len3, z3, a3, len4, z4, a4, len5;
  logic [LW-1:0] lead_c, trail_c;
  logic          c1, c2, mid_c, sign_c;
  logic [7:0]    sign_chc;

  // Emission signals
  logic       emit_req, out_free, app_ok, fire, flush, fin;
  logic [7:0] emit_ch;

  // Shift-and-add-3 adjust and per-digit extraction
  always_comb begin
    for (int i = 0; i < NDEC; i++) begin
      bcd_adj[i*4 +: 4] = (bcd[i*4 +: 4] >= 4'd5) ? bcd[i*4 +: 4] + 4'd3 : bcd[i*4 +: 4];
    end
    kmask     = 4'(5'd1 << d.radix) - 4'd1;
    gen_d     = (d.radix == RADIX_DEC) ? bcd[3:0] : (val[3:0] & kmask);
    val_sh    = val >> d.radix;
    bcd_sh    = bcd >> 4;
    rest_zero = (d.radix == RADIX_DEC) ? (bcd_sh == '0) : (val_sh == '0);
    comma_now = d.group && (gcnt == 2'd3);
    gen_ch    = comma_now ? CH_COMMA : itf_digit_char(gen_d, d.upper);
  end

  // Field layout: zeros, prefix trimming, sign and padding
  always_comb begin
    a0 = LW'(dlen);
    p  = LW'(d.prec);
    w  = LW'(d.width);
    sign_c = d.neg || d.plus || d.space;
    if (d.width != 8'd0 && d.zero_pad && sign_c) w = w - LW'(1);
    len1 = (a0 < p) ? p : a0;
    z1   = (a0 < p) ? p - a0 : '0;
    len2 = (d.zero_pad && len1 < w) ? w : len1;
    z2   = (d.zero_pad && len1 < w) ? z1 + (w - len1) : z1;
    mid_c = d.hash && (d.radix == RADIX_HEX || d.radix == RADIX_BIN);
    c1 = d.hash && (!d.prec_on || d.radix == RADIX_OCT) && len2 != '0 &&
         (len2 >= p || len2 >= w) && (z2 != '0 || d.mag_zero);
    len3 = len2; z3 = z2; a3 = a0;
    if (c1) begin
      z3   = (z2 != '0) ? z2 - LW'(1) : z2;
      len3 = len2 - LW'(1);
      a3   = (len3 < a0) ? len3 : a0;
    end
    c2 = c1 && len3 != '0 && mid_c && (z3 != '0 || d.mag_zero);
    len4 = len3; z4 = z3; a4 = a3;
    if (c2) begin
      z4   = (z3 != '0) ? z3 - LW'(1) : z3;
      len4 = len3 - LW'(1);
      a4   = (len4 < a3) ? len4 : a3;
    end
    len5 = len4 + LW'(d.hash) + LW'(mid_c) + LW'(sign_c);
    lead_c  = (!d.left && !d.zero_pad && len5 < w) ? w - len5 : '0;
    trail_c = (d.left && len5 < w) ? w - len5 : '0;
    sign_chc = d.neg ? CH_MINUS : (d.plus ? CH_PLUS : CH_SPACE);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (!q_empty) begin
          if (q_desc.mag_zero && q_desc.prec_on) state_next = S_LAYOUT;
          else if (q_desc.radix == RADIX_DEC) state_next = S_DABBLE;
          else state_next = S_GEN;
        end
      end
      S_DABBLE: if (bitcnt == BC_W'(VALUE_BITS-1)) state_next = S_GEN;
      S_GEN:    if (!comma_now && rest_zero) state_next = S_LAYOUT;
      S_LAYOUT: state_next = S_LEAD;
      S_LEAD:   if (lead == '0) state_next = S_SIGN;
      S_SIGN:   if (!has_sign || fire) state_next = S_PFX;
      S_PFX: begin
        if (!d.hash) state_next = S_ZERO;
        else if (fire) state_next = S_MID;
      end
      S_MID:    if (!has_mid || fire) state_next = S_ZERO;
      S_ZERO:   if (zeros == '0) state_next = S_DRD;
      S_DRD:    state_next = (act == '0) ? S_TRAIL : S_DPUT;
      S_DPUT:   if (fire) state_next = S_DRD;
      S_TRAIL:  if (trail == '0) state_next = S_FINAL;
      S_FINAL:  if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Character request per state
  always_comb begin
    emit_req = 1'b0;
    emit_ch  = CH_SPACE;
    unique case (state)
      S_LEAD:  emit_req = (lead != '0);
      S_SIGN:  begin emit_req = has_sign; emit_ch = sign_ch; end
      S_PFX:   begin emit_req = d.hash; emit_ch = CH_ZERO; end
      S_MID:   begin emit_req = has_mid; emit_ch = mid_ch; end
      S_ZERO:  begin emit_req = (zeros != '0); emit_ch = CH_ZERO; end
      S_DPUT:  begin emit_req = 1'b1; emit_ch = mem_q; end
      S_TRAIL: emit_req = (trail != '0);
      default: emit_req = 1'b0;
    endcase
  end

  assign out_free = !m_tvalid || m_tready;
  assign app_ok   = (cnt != CPR_C) || out_free;
  assign fire     = emit_req && app_ok;
  assign flush    = fire && (cnt == CPR_C);
  assign fin      = (state == S_FINAL) && out_free;
  assign q_pop    = (state == S_IDLE) && !q_empty;

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      chunk    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (flush || fin) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      // chunk assembly
      if (fin) begin
        chunk <= '0;
        cnt   <= '0;
      end else if (fire) begin
        if (cnt == CPR_C) begin
          chunk <= CK_W'(emit_ch);
          cnt   <= COUNT_BITS'(1);
        end else begin
          for (int i = 0; i < CHARS_PER_RESULT; i++) begin
            if (cnt == COUNT_BITS'(i)) chunk[i*8 +: 8] <= emit_ch;
          end
          cnt <= cnt + COUNT_BITS'(1);
        end
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (flush || fin) begin
      out_chunk <= chunk;
      out_cnt   <= cnt;
      m_tlast   <= fin;
    end
  end

  assign m_tdata = {4'd0, out_cnt, TEXT_BITS'(out_chunk)};

  // Datapath: conversion, layout and counters
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (!q_empty) begin
          d      <= q_desc;
          val    <= q_mag;
          bcd    <= '0;
          bitcnt <= '0;
          dlen   <= '0;
          gcnt   <= 2'd0;
        end
      end
      S_DABBLE: begin
        bcd    <= {bcd_adj[BCD_W-2:0], val[VALUE_BITS-1]};
        val    <= val << 1;
        bitcnt <= bitcnt + BC_W'(1);
      end
      S_GEN: begin
        dlen <= dlen + DL_W'(1);
        if (comma_now) begin
          gcnt <= 2'd0;
        end else begin
          gcnt <= gcnt + 2'd1;
          if (d.radix == RADIX_DEC) bcd <= bcd_sh;
          else val <= val_sh;
        end
      end
      S_LAYOUT: begin
        lead     <= lead_c;
        zeros    <= z4;
        act      <= a4[DL_W-1:0];
        trail    <= trail_c;
        has_sign <= sign_c;
        sign_ch  <= sign_chc;
        has_mid  <= mid_c;
        mid_ch   <= (d.radix == RADIX_BIN) ? CH_LB : (d.upper ? CH_UX : CH_LX);
      end
      S_LEAD:  if (fire) lead <= lead - LW'(1);
      S_ZERO:  if (fire) zeros <= zeros - LW'(1);
      S_DPUT:  if (fire) act <= act - DL_W'(1);
      S_TRAIL: if (fire) trail <= trail - LW'(1);
      default: ;
    endcase
  end

  // Digit memory: written during generation, read most significant first
  always_ff @(posedge clk) begin
    if (state == S_GEN) mem[dlen[DA_W-1:0]] <= gen_ch;
    mem_q <= mem[DA_W'(act - DL_W'(1))];
  end

endmodule

/* sv/integer_to_text_formatter.sv */
// Sequence: shift-and-add-3 conversion for decimal (none for power-of-two radices), then digit
//   and comma generation, then pad, sign, prefix and zero characters and the printed digits
//   (each through a registered digit-memory read), then trailing pads; a full chunk waits
//   for the output register to drain.
// The back-end sequencer finishes one number before it takes the next; a two-entry
//   queue lets the front take new numbers meanwhile, and an output register holds a chunk.
// Reset: synchronous rst clears queue, sequencer, chunk and output valid; digit memory is not.
module integer_to_text_formatter import itf_pkg::*; #(
  parameter int VALUE_BITS         = 128,
  parameter int DIGIT_BUFFER_DEPTH = 144,
  parameter int FIELD_LIMIT        = 255,
  parameter int CHARS_PER_RESULT   = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // value_low, value_high, sign_bit, radix_code, precision, field_width,
  // format_flags, upper_case, zero fill
  input  logic [IN_BITS-1:0]  s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  // text_chunk, chunk_count, zero fill
  output logic [OUT_BITS-1:0] m_tdata,
  output logic                m_tlast
);

  localparam int QW = VALUE_BITS + $bits(itf_desc_t);

  logic                  push, full, pop, empty;
  logic [VALUE_BITS-1:0] f_mag, q_mag;
  itf_desc_t             f_desc, q_desc;
  logic [QW-1:0]         q_rdata;

  itf_front #(
    .VALUE_BITS(VALUE_BITS),
    .FIELD_LIMIT(FIELD_LIMIT)
  ) u_front (
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .full(full),
    .push(push),
    .mag(f_mag),
    .desc(f_desc)
  );

  itf_queue #(
    .W(QW)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .wdata({f_mag, f_desc}),
    .full(full),
    .pop(pop),
    .rdata(q_rdata),
    .empty(empty)
  );

  assign q_mag  = q_rdata[QW-1 -: VALUE_BITS];
  assign q_desc = q_rdata[$bits(itf_desc_t)-1:0];

  itf_back #(
    .VALUE_BITS(VALUE_BITS),
    .DIGIT_BUFFER_DEPTH(DIGIT_BUFFER_DEPTH),
    .FIELD_LIMIT(FIELD_LIMIT),
    .CHARS_PER_RESULT(CHARS_PER_RESULT)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_empty(empty),
    .q_mag(q_mag),
    .q_desc(q_desc),
    .q_pop(pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast)
  );

endmodule

/* sv/itf_checker.sv */
`include "integer_to_text_formatter_macros.svh"

module itf_checker import itf_pkg::*; #(
  parameter int CHARS_PER_RESULT = 8
) (
  input logic                clk,
  input logic                rst,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [OUT_BITS-1:0] m_tdata,
  input logic                m_tlast
);

  logic [COUNT_BITS-1:0] cnt;
  logic [TEXT_BITS-1:0]  text;

  assign cnt  = m_tdata[67:64];
  assign text = m_tdata[63:0];

  // a stalled transaction holds
  `ITF_CHK_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output changed while stalled")
  // only the final chunk may be short
  `ITF_CHK_NOW(a_full, m_tvalid && !m_tlast, cnt == COUNT_BITS'(CHARS_PER_RESULT), "short chunk before the last")
  // an empty chunk only ends an empty text
  `ITF_CHK_NOW(a_empty, m_tvalid && cnt == '0, m_tlast && text == '0, "empty chunk not last or not zero")
  // bytes past the count are zero
  `ITF_CHK_NOW(a_unused, m_tvalid, (text >> ({3'd0, cnt} * 7'd8)) == '0, "unused bytes not zero")

endmodule

bind integer_to_text_formatter itf_checker #(
  .CHARS_PER_RESULT(CHARS_PER_RESULT)
) u_itf_checker (
  .clk(clk),
  .rst(rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata(m_tdata),
  .m_tlast(m_tlast)
);
